FILE: rtl/core/ftli_pkg.sv
// Shared constants, types and codes for the flow table lookup and insert block.
`timescale 1ns / 1ps

package ftli_pkg;

    localparam int FLOW_CAPACITY = 1024;
    localparam int IDX_W = (FLOW_CAPACITY > 1) ? $clog2(FLOW_CAPACITY) : 1;
    localparam int CNT_W = $clog2(FLOW_CAPACITY + 1);

    localparam int OUT_IDX_W = 10;
    localparam int OUT_CNT_W = 11;

    localparam logic [15:0] MIN_CAPTURE_LEN = 16'd20;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [15:0] TCP_MIN_L4_LEN  = 16'd20;
    localparam logic [15:0] UDP_MIN_L4_LEN  = 16'd8;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] lower_addr;
        logic [31:0] upper_addr;
        logic [15:0] lo_port;
        logic [15:0] hi_port;
    } flow_key_t;

    localparam int KEY_W = $bits(flow_key_t);

    typedef enum logic [1:0] {
        STATUS_FOUND    = 2'd0,
        STATUS_INSERTED = 2'd1,
        STATUS_REJECTED = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

endpackage

FILE: rtl/core/ftli_if.sv
// Handshake interfaces for the packet header channel and the lookup result channel.
`timescale 1ns / 1ps

interface ftli_pkt_if;
    logic        valid;
    logic        ready;
    logic [15:0] captured_ip_len;
    logic [3:0]  header_words;
    logic [15:0] total_length;
    logic [12:0] frag_offset;
    logic [7:0]  ip_protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;

    modport source (
        output valid, captured_ip_len, header_words, total_length, frag_offset,
               ip_protocol, src_addr, dst_addr, src_port, dst_port,
        input  ready
    );

    modport sink (
        input  valid, captured_ip_len, header_words, total_length, frag_offset,
               ip_protocol, src_addr, dst_addr, src_port, dst_port,
        output ready
    );
endinterface

interface ftli_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [9:0]  flow_index;
    logic [10:0] flows_in_use;

    modport source (
        output valid, status, flow_index, flows_in_use,
        input  ready
    );

    modport sink (
        input  valid, status, flow_index, flows_in_use,
        output ready
    );
endinterface

FILE: rtl/core/ftli_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module ftli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/flow_table_lookup_insert.sv
// Top level: IPv4 header check, canonical five-tuple, linear table search with insert.
//
//  channel | dir | transaction payload
//  --------+-----+-------------------------------------------------------------
//  pkt     | in  | captured_ip_len, header_words, total_length, frag_offset,
//          |     | ip_protocol, src_addr, dst_addr, src_port, dst_port
//  res     | out | status, flow_index, flows_in_use
//
// A rejected packet skips the search and goes from idle straight to the emit state.
// A search reads one entry a cycle from the single read port of the entry RAM;
// a hit ends the search, and a miss reads every entry in use and then inserts the
// key or reports the table full, so a search reads at most FLOW_CAPACITY entries.
// Reset clears the entry count and the control state; the entry RAM needs no clearing pass.
// The result waits in an output register, and the next transaction is accepted
// while it waits; a stalled result holds only the following transaction's end.
`timescale 1ns / 1ps

module flow_table_lookup_insert (
    input  logic       clk,
    input  logic       rst_n,
    ftli_pkt_if.sink   pkt,
    ftli_res_if.source res
);

    ftli_pkg::state_t               state_reg, state_next;
    logic [ftli_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [ftli_pkg::CNT_W-1:0]     ptr_reg, ptr_next;
    logic                           pend_reg, pend_next;
    logic [ftli_pkg::CNT_W-1:0]     pend_idx_reg, pend_idx_next;
    ftli_pkg::flow_key_t            key_reg, key_next;
    ftli_pkg::status_t              rstat_reg, rstat_next;
    logic [ftli_pkg::CNT_W-1:0]     ridx_reg, ridx_next;
    logic [ftli_pkg::CNT_W-1:0]     rcnt_reg, rcnt_next;
    logic                           out_valid_reg, out_valid_next;
    ftli_pkg::status_t              out_status_reg, out_status_next;
    logic [ftli_pkg::OUT_IDX_W-1:0] out_index_reg, out_index_next;
    logic [ftli_pkg::OUT_CNT_W-1:0] out_count_reg, out_count_next;

    logic                           accept;
    logic                           reject;
    logic [15:0]                    hdr_len;
    logic [15:0]                    l4_len;
    logic                           src_low;
    logic                           keep_ports;
    ftli_pkg::flow_key_t            in_key;
    logic [ftli_pkg::KEY_W-1:0]     rd_data;
    logic                           rd_en;
    logic                           wr_en;
    logic                           hit;
    logic                           scan_done;
    logic                           table_full;
    logic [31:0]                    ridx_wide;
    logic [31:0]                    rcnt_wide;

    assign accept     = pkt.valid && pkt.ready;
    assign hit        = pend_reg && (rd_data == key_reg);
    assign scan_done  = (ptr_reg == count_reg);
    assign table_full = (count_reg == ftli_pkg::CNT_W'(ftli_pkg::FLOW_CAPACITY));
    assign rd_en      = (state_reg == ftli_pkg::ST_SEARCH) && !hit && !scan_done;
    assign wr_en      = (state_reg == ftli_pkg::ST_SEARCH) && !hit && scan_done && !table_full;
    assign ridx_wide  = 32'(ridx_reg);
    assign rcnt_wide  = 32'(rcnt_reg);

    always_comb
    begin
        hdr_len = {10'd0, pkt.header_words, 2'b00};
        l4_len  = pkt.total_length - hdr_len;
        reject  = (pkt.captured_ip_len < ftli_pkg::MIN_CAPTURE_LEN)
                  || (hdr_len > pkt.captured_ip_len)
                  || (pkt.captured_ip_len < pkt.total_length)
                  || (pkt.frag_offset != '0);
        src_low = pkt.src_addr < pkt.dst_addr;
        keep_ports = ((pkt.ip_protocol == ftli_pkg::PROTO_TCP)
                      && (l4_len >= ftli_pkg::TCP_MIN_L4_LEN))
                     || ((pkt.ip_protocol == ftli_pkg::PROTO_UDP)
                      && (l4_len >= ftli_pkg::UDP_MIN_L4_LEN));
        in_key.protocol   = pkt.ip_protocol;
        in_key.lower_addr = src_low ? pkt.src_addr : pkt.dst_addr;
        in_key.upper_addr = src_low ? pkt.dst_addr : pkt.src_addr;
        in_key.lo_port    = !keep_ports ? 16'd0 : (src_low ? pkt.src_port : pkt.dst_port);
        in_key.hi_port    = !keep_ports ? 16'd0 : (src_low ? pkt.dst_port : pkt.src_port);
    end

    ftli_ram #(
        .WIDTH (ftli_pkg::KEY_W),
        .DEPTH (ftli_pkg::FLOW_CAPACITY)
    ) u_entries (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ftli_pkg::IDX_W-1:0]),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg[ftli_pkg::IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        key_next        = key_reg;
        rstat_next      = rstat_reg;
        ridx_next       = ridx_reg;
        rcnt_next       = rcnt_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_count_next  = out_count_reg;
        pkt.ready       = (state_reg == ftli_pkg::ST_IDLE);

        unique case (state_reg)
            ftli_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    key_next  = in_key;
                    ptr_next  = '0;
                    pend_next = 1'b0;
                    if (reject)
                    begin
                        rstat_next = ftli_pkg::STATUS_REJECTED;
                        ridx_next  = '0;
                        rcnt_next  = count_reg;
                        state_next = ftli_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = ftli_pkg::ST_SEARCH;
                    end
                end
            end
            ftli_pkg::ST_SEARCH:
            begin
                priority if (hit)
                begin
                    rstat_next = ftli_pkg::STATUS_FOUND;
                    ridx_next  = pend_idx_reg;
                    rcnt_next  = count_reg;
                    state_next = ftli_pkg::ST_EMIT;
                end
                else if (scan_done)
                begin
                    if (table_full)
                    begin
                        rstat_next = ftli_pkg::STATUS_FULL;
                        ridx_next  = '0;
                        rcnt_next  = count_reg;
                    end
                    else
                    begin
                        rstat_next = ftli_pkg::STATUS_INSERTED;
                        ridx_next  = count_reg;
                        rcnt_next  = count_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = ftli_pkg::ST_EMIT;
                end
                else
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = ptr_reg;
                    ptr_next      = ptr_reg + 1'b1;
                end
            end
            ftli_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = rstat_reg;
                    out_index_next  = ridx_wide[ftli_pkg::OUT_IDX_W-1:0];
                    out_count_next  = rcnt_wide[ftli_pkg::OUT_CNT_W-1:0];
                    state_next      = ftli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ftli_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ftli_pkg::ST_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        key_reg        <= key_next;
        rstat_reg      <= rstat_next;
        ridx_reg       <= ridx_next;
        rcnt_reg       <= rcnt_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_count_reg  <= out_count_next;
    end

    assign res.valid        = out_valid_reg;
    assign res.status       = out_status_reg;
    assign res.flow_index   = out_index_reg;
    assign res.flows_in_use = out_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ftli_pkg::CNT_W'(ftli_pkg::FLOW_CAPACITY))
        else $error("Entry count exceeds the table capacity.");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ftli_pkg::ST_SEARCH) |-> (ptr_reg <= count_reg))
        else $error("Search pointer ran past the entries in use.");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == ftli_pkg::CNT_W'($past(count_reg) + 1'b1)))
        else $error("Insert did not advance the entry count by one.");

    a_found_index: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && (res.status == ftli_pkg::STATUS_FOUND))
        |-> (32'(res.flow_index) < 32'(res.flows_in_use)))
        else $error("Found flow index is not below the entries in use.");

    a_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && ((res.status == ftli_pkg::STATUS_REJECTED)
                       || (res.status == ftli_pkg::STATUS_FULL)))
        |-> (res.flow_index == '0))
        else $error("Rejected or full result carries a nonzero index.");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the flow table block: header checks, canonical keys, table fill.
`timescale 1ns / 1ps

module tb;
    import ftli_pkg::*;

    localparam int CYCLE_LIMIT    = 8_000_000;
    localparam int RANDOM_PACKETS = 500;
    localparam int SETTLE_CYCLES  = FLOW_CAPACITY + 16;
    localparam int REPORT_LIMIT   = 100;

    typedef struct packed {
        logic [15:0] captured_ip_len;
        logic [3:0]  header_words;
        logic [15:0] total_length;
        logic [12:0] frag_offset;
        logic [7:0]  ip_protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } header_t;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [31:0] addr_a;
        logic [31:0] addr_b;
        logic [15:0] port_a;
        logic [15:0] port_b;
        logic [15:0] l4_len;
    } flow_t;

    typedef struct packed {
        status_t              status;
        logic [OUT_IDX_W-1:0] flow_index;
        logic [OUT_CNT_W-1:0] flows_in_use;
    } lookup_t;

    logic clk;
    logic rst_n;

    ftli_pkt_if pkt_ch ();
    ftli_res_if res_ch ();

    flow_table_lookup_insert dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pkt   (pkt_ch.sink),
        .res   (res_ch.source)
    );

    flow_key_t key_table [FLOW_CAPACITY];
    int        keys_stored = 0;
    lookup_t   lookups_due [$];
    flow_t     flow_pool [$];
    header_t   first_flow_header;
    int        mismatch_count = 0;
    int        hold_cycles = 0;
    bit        sender_steady = 1'b0;
    longint    cycle_count = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        if (mismatch_count < REPORT_LIMIT)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic lookup_t predict_lookup(header_t h);
        lookup_t    r;
        logic [17:0] hlen;
        logic [15:0] l4_len;
        logic        src_low;
        logic        keep_ports;
        flow_key_t   key;
        r.status = STATUS_REJECTED;
        r.flow_index = '0;
        r.flows_in_use = OUT_CNT_W'(keys_stored);
        hlen = {12'd0, h.header_words, 2'b00};
        if (h.captured_ip_len < MIN_CAPTURE_LEN || hlen > h.captured_ip_len ||
            h.captured_ip_len < h.total_length || h.frag_offset != '0)
            return r;
        l4_len = h.total_length - hlen[15:0];
        src_low = h.src_addr < h.dst_addr;
        keep_ports = (h.ip_protocol == PROTO_TCP && l4_len >= TCP_MIN_L4_LEN) ||
                     (h.ip_protocol == PROTO_UDP && l4_len >= UDP_MIN_L4_LEN);
        key.protocol   = h.ip_protocol;
        key.lower_addr = src_low ? h.src_addr : h.dst_addr;
        key.upper_addr = src_low ? h.dst_addr : h.src_addr;
        key.lo_port    = !keep_ports ? 16'd0 : (src_low ? h.src_port : h.dst_port);
        key.hi_port    = !keep_ports ? 16'd0 : (src_low ? h.dst_port : h.src_port);
        for (int i = 0; i < keys_stored; i++)
        begin
            if (key_table[i] == key)
            begin
                r.status = STATUS_FOUND;
                r.flow_index = OUT_IDX_W'(i);
                return r;
            end
        end
        if (keys_stored >= FLOW_CAPACITY)
        begin
            r.status = STATUS_FULL;
            return r;
        end
        key_table[keys_stored] = key;
        r.status = STATUS_INSERTED;
        r.flow_index = OUT_IDX_W'(keys_stored);
        keys_stored++;
        r.flows_in_use = OUT_CNT_W'(keys_stored);
        return r;
    endfunction

    function automatic int pick_idle(int zero_pct);
        int r;
        r = $urandom_range(99);
        if (r < zero_pct)
            return 0;
        if (r < zero_pct + (100 - zero_pct) * 2 / 3)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(80, 20);
    endfunction

    task automatic send_header(header_t h);
        int gap;
        gap = sender_steady ? 0 : pick_idle(50);
        if (gap > 0)
        begin
            @(negedge clk);
            pkt_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pkt_ch.valid           <= 1'b1;
        pkt_ch.captured_ip_len <= h.captured_ip_len;
        pkt_ch.header_words    <= h.header_words;
        pkt_ch.total_length    <= h.total_length;
        pkt_ch.frag_offset     <= h.frag_offset;
        pkt_ch.ip_protocol     <= h.ip_protocol;
        pkt_ch.src_addr        <= h.src_addr;
        pkt_ch.dst_addr        <= h.dst_addr;
        pkt_ch.src_port        <= h.src_port;
        pkt_ch.dst_port        <= h.dst_port;
        do @(posedge clk); while (!pkt_ch.ready);
        lookups_due.push_back(predict_lookup(h));
    endtask

    task automatic wait_results_drained();
        @(negedge clk);
        pkt_ch.valid <= 1'b0;
        while (lookups_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int  stall_left;
        int  calm_left;
        bit  calm;
        res_ch.ready = 1'b0;
        stall_left = 0;
        calm_left = 0;
        calm = 1'b0;
        forever
        begin
            @(negedge clk);
            if (calm_left == 0)
            begin
                calm = ($urandom_range(3) == 0);
                calm_left = 300;
            end
            calm_left--;
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                res_ch.ready <= 1'b0;
            end
            else if (!rst_n)
                res_ch.ready <= 1'b0;
            else
            begin
                if (stall_left == 0 && !calm)
                    stall_left = pick_idle(70);
                if (stall_left > 0)
                begin
                    stall_left--;
                    res_ch.ready <= 1'b0;
                end
                else
                    res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        lookup_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (lookups_due.size() == 0)
                report_mismatch("result transaction with no lookup outstanding");
            else
            begin
                want = lookups_due.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %s",
                                              res_ch.status, want.status.name()));
                if (res_ch.flow_index !== want.flow_index)
                    report_mismatch($sformatf("flow_index %0d, expected %0d",
                                              res_ch.flow_index, want.flow_index));
                if (res_ch.flows_in_use !== want.flows_in_use)
                    report_mismatch($sformatf("flows_in_use %0d, expected %0d",
                                              res_ch.flows_in_use, want.flows_in_use));
            end
        end
    end

    function automatic header_t hdr(int cap, int hw, int tot, int frag, logic [7:0] proto,
                                    logic [31:0] sa, logic [31:0] da,
                                    logic [15:0] sp, logic [15:0] dp);
        header_t h;
        h.captured_ip_len = 16'(cap);
        h.header_words    = 4'(hw);
        h.total_length    = 16'(tot);
        h.frag_offset     = 13'(frag);
        h.ip_protocol     = proto;
        h.src_addr        = sa;
        h.dst_addr        = da;
        h.src_port        = sp;
        h.dst_port        = dp;
        return h;
    endfunction

    function automatic flow_t new_flow();
        flow_t f;
        int    r;
        r = $urandom_range(9);
        f.protocol = (r < 4) ? PROTO_TCP : (r < 8) ? PROTO_UDP : 8'($urandom);
        f.addr_a = $urandom;
        r = $urandom_range(9);
        if (r == 0)
            f.addr_b = f.addr_a;
        else if (r == 1)
            f.addr_b = f.addr_a ^ (32'd1 << $urandom_range(31));
        else
            f.addr_b = $urandom;
        f.port_a = 16'($urandom);
        f.port_b = 16'($urandom);
        f.l4_len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(40));
        return f;
    endfunction

    function automatic header_t make_header(flow_t f, bit reversed);
        header_t h;
        int      hlen;
        int      tot;
        int      cap;
        h.header_words = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd5;
        hlen = h.header_words * 4;
        tot = (hlen + f.l4_len) % 65536;
        cap = tot;
        if (cap < hlen)
            cap = hlen;
        if (cap < 20)
            cap = 20;
        if ($urandom_range(2) != 0)
            cap += $urandom_range(40);
        if (cap > 65535)
            cap = 65535;
        h.captured_ip_len = 16'(cap);
        h.total_length    = 16'(tot);
        h.frag_offset     = '0;
        h.ip_protocol     = f.protocol;
        h.src_addr        = reversed ? f.addr_b : f.addr_a;
        h.dst_addr        = reversed ? f.addr_a : f.addr_b;
        h.src_port        = reversed ? f.port_b : f.port_a;
        h.dst_port        = reversed ? f.port_a : f.port_b;
        return h;
    endfunction

    function automatic header_t break_header(header_t h);
        int hlen;
        int cap;
        case ($urandom_range(3))
            0: h.captured_ip_len = 16'($urandom_range(19));
            1:
            begin
                h.header_words = 4'($urandom_range(15, 6));
                hlen = h.header_words * 4;
                cap = $urandom_range(hlen - 1, 20);
                h.captured_ip_len = 16'(cap);
                h.total_length = 16'($urandom_range(cap));
            end
            2:
            begin
                if (h.captured_ip_len == 16'hFFFF)
                    h.captured_ip_len = 16'hFFFE;
                cap = h.captured_ip_len;
                h.total_length = 16'($urandom_range(65535, cap + 1));
            end
            default: h.frag_offset = 13'($urandom_range(8191, 1));
        endcase
        return h;
    endfunction

    function automatic header_t noise_header();
        return hdr($urandom, $urandom, $urandom, $urandom, 8'($urandom),
                   $urandom, $urandom, 16'($urandom), 16'($urandom));
    endfunction

    function automatic header_t pool_header(bit reversed);
        return make_header(flow_pool[$urandom_range(flow_pool.size() - 1)], reversed);
    endfunction

    task automatic test_header_checks();
        send_header(hdr(19, 5, 19, 0, PROTO_TCP, 32'h0A000001, 32'h0A000002, 16'd1000, 16'd80));
        first_flow_header = hdr(20, 5, 20, 0, PROTO_TCP, 32'h0A000001, 32'h0A000002,
                                16'd1000, 16'd80);
        send_header(first_flow_header);
        send_header(hdr(59, 15, 40, 0, PROTO_TCP, 32'h0A000001, 32'h0A000002, 16'd1, 16'd2));
        send_header(hdr(100, 5, 101, 0, PROTO_UDP, 32'h0A000001, 32'h0A000002, 16'd1, 16'd2));
        send_header(hdr(100, 5, 60, 1, PROTO_UDP, 32'h0A000001, 32'h0A000002, 16'd1, 16'd2));
        send_header(hdr(100, 5, 60, 8191, PROTO_UDP, 32'h0A000001, 32'h0A000002, 16'd1, 16'd2));
        send_header(hdr(20, 0, 20, 0, PROTO_TCP, 32'h01020304, 32'h05060708, 16'd11, 16'd22));
        send_header(hdr(40, 4, 40, 0, PROTO_UDP, 32'h01020304, 32'h05060708, 16'd11, 16'd22));
        send_header(hdr(60, 15, 30, 0, PROTO_TCP, 32'h01020304, 32'h05060708, 16'd33, 16'd44));
        send_header(hdr(65535, 15, 65535, 0, 8'hFF, 32'hFFFFFFFF, 32'h00000000,
                        16'hFFFF, 16'h0000));
        send_header(hdr(65535, 5, 65535, 0, 8'h00, 32'h00000000, 32'hFFFFFFFF,
                        16'h0000, 16'hFFFF));
        wait_results_drained();
    endtask

    task automatic test_canonical_keys();
        send_header(hdr(40, 5, 40, 0, PROTO_TCP, 32'hC0A80001, 32'h0A000001, 16'd443, 16'd51000));
        send_header(hdr(40, 5, 40, 0, PROTO_TCP, 32'h0A000001, 32'hC0A80001, 16'd51000, 16'd443));
        send_header(hdr(39, 5, 39, 0, PROTO_TCP, 32'hC0A80001, 32'h0A000001, 16'd443, 16'd51000));
        send_header(hdr(39, 5, 39, 0, PROTO_TCP, 32'hC0A80001, 32'h0A000001, 16'd7, 16'd9));
        send_header(hdr(28, 5, 28, 0, PROTO_UDP, 32'hC0A80001, 32'h0A000001, 16'd53, 16'd5353));
        send_header(hdr(27, 5, 27, 0, PROTO_UDP, 32'hC0A80001, 32'h0A000001, 16'd53, 16'd5353));
        send_header(hdr(1500, 5, 1500, 0, 8'd1, 32'hC0A80001, 32'h0A000001, 16'd7, 16'd9));
        send_header(hdr(1500, 5, 1500, 0, 8'd1, 32'h0A000001, 32'hC0A80001, 16'd8, 16'd3));
        send_header(hdr(40, 5, 40, 0, PROTO_TCP, 32'h7F000001, 32'h7F000001, 16'd1111, 16'd2222));
        send_header(hdr(40, 5, 40, 0, PROTO_TCP, 32'h7F000001, 32'h7F000001, 16'd2222, 16'd1111));
        send_header(hdr(40, 5, 40, 0, PROTO_TCP, 32'h7F000001, 32'h7F000001, 16'd1111, 16'd2222));
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        header_t h;
        int      r;
        for (int n = 0; n < RANDOM_PACKETS; n++)
        begin
            if (n % 50 == 0)
                sender_steady = ($urandom_range(3) == 0);
            r = $urandom_range(99);
            if (r < 20 || flow_pool.size() == 0)
            begin
                flow_pool.push_back(new_flow());
                h = make_header(flow_pool[flow_pool.size() - 1], $urandom_range(1));
            end
            else if (r < 75)
                h = pool_header($urandom_range(1));
            else if (r < 90)
                h = break_header(pool_header(1'b0));
            else
                h = noise_header();
            send_header(h);
            if (n == RANDOM_PACKETS / 2)
                wait_results_drained();
        end
        sender_steady = 1'b0;
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        hold_cycles = 600;
        sender_steady = 1'b1;
        for (int n = 0; n < 24; n++)
        begin
            if (n % 3 == 0)
                send_header(break_header(pool_header(1'b0)));
            else
                send_header(pool_header($urandom_range(1)));
        end
        sender_steady = 1'b0;
        wait_results_drained();
    endtask

    task automatic test_table_full();
        header_t last_insert;
        int      n;
        n = 0;
        while (keys_stored < FLOW_CAPACITY)
        begin
            last_insert = hdr(28, 5, 28, 0, PROTO_UDP, 32'hE0000000 + n, 32'hE1000000,
                              16'(n), 16'd4789);
            send_header(last_insert);
            n++;
        end
        send_header(hdr(28, 5, 28, 0, PROTO_UDP, 32'hE2000000, 32'hE1000000, 16'd1, 16'd2));
        send_header(make_header(new_flow(), 1'b0));
        send_header(first_flow_header);
        send_header(last_insert);
        send_header(hdr(28, 5, 28, 0, PROTO_UDP, last_insert.dst_addr, last_insert.src_addr,
                        last_insert.dst_port, last_insert.src_port));
        send_header(break_header(last_insert));
        send_header(pool_header(1'b1));
        send_header(hdr(28, 5, 28, 0, PROTO_TCP, 32'hE2000001, 32'hE1000000, 16'd1, 16'd2));
        wait_results_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        pkt_ch.valid = 1'b0;
        pkt_ch.captured_ip_len = '0;
        pkt_ch.header_words = '0;
        pkt_ch.total_length = '0;
        pkt_ch.frag_offset = '0;
        pkt_ch.ip_protocol = '0;
        pkt_ch.src_addr = '0;
        pkt_ch.dst_addr = '0;
        pkt_ch.src_port = '0;
        pkt_ch.dst_port = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_header_checks();
        test_canonical_keys();
        test_random_traffic();
        test_backpressure();
        test_table_full();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && lookups_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
